@@ rtl/core/wem_pkg.sv @@
// ----------------------------------------------------------------------------
// Window edge magnitude package
// Shared sample and pixel types, register codes and the edge-strength function
// used by the line stores, the window and the top level.
// ----------------------------------------------------------------------------
package wem_pkg;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned CFG_DATA_W = 11;
  localparam int unsigned CFG_IDX_W  = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

  localparam logic [CFG_DATA_W-1:0] FRAME_WIDTH_RST  = 11'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_HEIGHT_RST = 11'd480;

  typedef logic [SAMPLE_W-1:0] sample_t;

  localparam sample_t SAMPLE_MAX = 8'hFF;

  typedef struct packed {
    sample_t red;
    sample_t green;
    sample_t blue;
  } pixel_t;

  localparam pixel_t PIXEL_OUTSIDE = '{red: SAMPLE_MAX, green: SAMPLE_MAX, blue: SAMPLE_MAX};

  typedef struct packed {
    pixel_t upper;
    pixel_t middle;
  } line_word_t;

  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  typedef struct packed {
    logic emit;
    logic top_out;
    logic bot_out;
    logic left_out;
    logic right_out;
    logic last;
  } win_ctl_t;

  function automatic sample_t abs_diff(sample_t a, sample_t b);
    return (a > b) ? sample_t'(a - b) : sample_t'(b - a);
  endfunction

  function automatic sample_t edge_strength(
    sample_t v00, sample_t v01, sample_t v02,
    sample_t v10, sample_t v12,
    sample_t v20, sample_t v21, sample_t v22
  );
    sample_t d_diag;
    sample_t d_vert;
    sample_t d_horz;
    sample_t d_anti;
    sample_t m_a;
    sample_t m_b;
    d_diag = abs_diff(v00, v22);
    d_vert = abs_diff(v01, v21);
    d_horz = abs_diff(v10, v12);
    d_anti = abs_diff(v02, v20);
    m_a = (d_vert > d_diag) ? d_vert : d_diag;
    m_b = (d_anti > d_horz) ? d_anti : d_horz;
    return (m_b > m_a) ? m_b : m_a;
  endfunction

endpackage

@@ rtl/core/wem_if.sv @@
// ----------------------------------------------------------------------------
// Window edge magnitude stream interfaces
// Valid/ready channels for incoming pixels and for edge results.
// ----------------------------------------------------------------------------
interface wem_in_if import wem_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t blue_in;
  sample_t green_in;
  sample_t red_in;
  logic    flush;

  modport source (output valid, output blue_in, output green_in, output red_in,
                  output flush, input ready);
  modport sink (input valid, input blue_in, input green_in, input red_in,
                input flush, output ready);
endinterface

interface wem_out_if import wem_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t blue_edge;
  sample_t green_edge;
  sample_t red_edge;
  logic    last_of_frame;

  modport source (output valid, output blue_edge, output green_edge, output red_edge,
                  output last_of_frame, input ready);
  modport sink (input valid, input blue_edge, input green_edge, input red_edge,
                input last_of_frame, output ready);
endinterface

@@ rtl/core/window_edge_magnitude_rgb.sv @@
// ----------------------------------------------------------------------------
// Window edge magnitude, RGB
// Raster-order 3x3 edge-strength detector with two line stores in one memory,
// a position sequencer and a window stage with registered results.
// ----------------------------------------------------------------------------
// Throughput: one item per clock cycle unless the output channel stalls, bounded
// by the line store's single read and single write per cycle.
// Results: the item completing a window passes the input register, the window
// and the result register, that item being frame_width+1 items after the pixel.
// Reset: positions return to zero, the window holds 255, the registers hold
// 640 and 480; the line stores are not cleared and need no clearing pass.
module window_edge_magnitude_rgb import wem_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  wem_in_if.sink                in_ch,
  wem_out_if.source             out_ch
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 2);

  logic [CFG_DATA_W-1:0] frame_width_r;
  logic [CFG_DATA_W-1:0] frame_height_r;
  logic [WW-1:0]         w;
  logic [HW-1:0]         h;
  logic                  cfg_hit;

  logic [CW-1:0] col_r;
  logic [RW-1:0] row_r;
  logic [CW-1:0] col;
  logic [CW-1:0] col_nxt;
  logic [RW-1:0] row_nxt;
  logic          col_nz;
  logic          row_end;
  logic [RW-1:0] cen_row;
  logic [CW-1:0] cen_col;
  win_ctl_t      ctl;

  logic          accept;
  logic          v1_r;
  logic          s1_go;
  logic          s2_free;
  pixel_t        s1_pix_r;
  logic [CW-1:0] s1_addr_r;
  win_ctl_t      s1_ctl_r;
  line_word_t    rd_data;
  line_word_t    wr_data;
  column_t       new_col;

  assign cfg_hit = cfg_we &&
                   (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= FRAME_WIDTH_RST;
      frame_height_r <= FRAME_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  frame_width_r  <= cfg_wdata;
        REG_FRAME_HEIGHT: frame_height_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (frame_width_r == '0) begin
      w = WW'(1);
    end else if (32'(frame_width_r) > MAX_WIDTH) begin
      w = WW'(MAX_WIDTH);
    end else begin
      w = WW'(frame_width_r);
    end
    if (frame_height_r == '0) begin
      h = HW'(1);
    end else if (32'(frame_height_r) > MAX_HEIGHT) begin
      h = HW'(MAX_HEIGHT);
    end else begin
      h = HW'(frame_height_r);
    end
  end

  always_comb begin
    col     = (WW'(col_r) >= w) ? '0 : col_r;
    col_nz  = (col != '0);
    cen_row = row_r - (col_nz ? RW'(1) : RW'(2));
    cen_col = col_nz ? CW'(col - CW'(1)) : CW'(w - WW'(1));
    if (col_nz) begin
      ctl.emit = (row_r >= RW'(1)) && (row_r <= RW'(h));
    end else begin
      ctl.emit = (row_r >= RW'(2)) && (row_r <= RW'(h) + RW'(1));
    end
    ctl.top_out   = (cen_row == '0);
    ctl.bot_out   = (cen_row == RW'(h) - RW'(1));
    ctl.left_out  = (cen_col == '0);
    ctl.right_out = (cen_col == CW'(w - WW'(1)));
    ctl.last      = ctl.emit && ctl.bot_out && ctl.right_out;
    row_end       = (WW'(col) + WW'(1) >= w);
    if (ctl.last) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (row_end) begin
      col_nxt = '0;
      row_nxt = row_r + RW'(1);
    end else begin
      col_nxt = col + CW'(1);
      row_nxt = row_r;
    end
  end

  assign s1_go       = v1_r && s2_free;
  assign in_ch.ready = !v1_r || s1_go;
  assign accept      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else if (cfg_hit) begin
      col_r <= '0;
      row_r <= '0;
    end else if (accept) begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (accept) begin
      v1_r <= 1'b1;
    end else if (s1_go) begin
      v1_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix_r  <= in_ch.flush ? PIXEL_OUTSIDE :
                   pixel_t'{red: in_ch.red_in, green: in_ch.green_in, blue: in_ch.blue_in};
      s1_addr_r <= col;
      s1_ctl_r  <= ctl;
    end
  end

  assign wr_data = '{upper: rd_data.middle, middle: s1_pix_r};
  assign new_col = '{top: rd_data.upper, mid: rd_data.middle, bot: s1_pix_r};

  wem_line_mem #(
    .DEPTH (MAX_WIDTH)
  ) u_line_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (accept),
    .rd_addr (col),
    .wr_en   (s1_go),
    .wr_addr (s1_addr_r),
    .wr_data (wr_data),
    .rd_data (rd_data)
  );

  wem_window_edge u_window (
    .clk      (clk),
    .rst_n    (rst_n),
    .shift_en (s1_go),
    .col_in   (new_col),
    .ctl_in   (s1_ctl_r),
    .s2_free  (s2_free),
    .out_ch   (out_ch)
  );

  a_cfg_restarts_frame: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (col_r == '0 && row_r == '0))
    else $error("Positions did not return to zero after a register write.");

  a_col_within_width: assert property (@(posedge clk) disable iff (!rst_n)
    WW'(col_r) < w)
    else $error("Column position ran past the frame width.");

  a_row_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    row_r <= RW'(h) + RW'(1))
    else $error("Row position ran past the end of the frame.");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (v1_r && !s2_free))
    else $error("Input stalled while the pipeline had room.");

endmodule

@@ rtl/core/wem_line_mem.sv @@
// ----------------------------------------------------------------------------
// Window edge magnitude line store
// One-read one-write synchronous memory holding the two rows above the
// incoming column, with write-to-read forwarding for the same entry.
// ----------------------------------------------------------------------------
module wem_line_mem import wem_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  line_word_t               wr_data,
  output line_word_t               rd_data
);

  line_word_t mem_r [DEPTH];
  line_word_t rd_data_r;
  line_word_t fwd_data_r;
  logic       fwd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r  <= mem_r[rd_addr];
      fwd_data_r <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_r <= 1'b0;
    end else if (rd_en) begin
      fwd_r <= wr_en && (wr_addr == rd_addr);
    end
  end

  assign rd_data = fwd_r ? fwd_data_r : rd_data_r;

endmodule

@@ rtl/core/wem_window_edge.sv @@
// ----------------------------------------------------------------------------
// Window edge magnitude window and result stage
// Holds the 3x3 window, masks neighbours outside the frame and registers the
// per-channel edge strength for the output channel.
// ----------------------------------------------------------------------------
module wem_window_edge import wem_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        shift_en,
  input  column_t     col_in,
  input  win_ctl_t    ctl_in,
  output logic        s2_free,
  wem_out_if.source   out_ch
);

  pixel_t   win_r [3][3];
  pixel_t   view [3][3];
  logic     v2_r;
  win_ctl_t ctl2_r;
  logic     o_en;
  logic     out_valid_r;
  sample_t  blue_edge_r;
  sample_t  green_edge_r;
  sample_t  red_edge_r;
  logic     last_r;

  assign o_en    = !out_valid_r || out_ch.ready;
  assign s2_free = !v2_r || o_en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int x = 0; x < 3; x++) begin
        for (int z = 0; z < 3; z++) begin
          win_r[x][z] <= PIXEL_OUTSIDE;
        end
      end
    end else if (shift_en) begin
      for (int x = 0; x < 3; x++) begin
        win_r[x][0] <= win_r[x][1];
        win_r[x][1] <= win_r[x][2];
      end
      win_r[0][2] <= col_in.top;
      win_r[1][2] <= col_in.mid;
      win_r[2][2] <= col_in.bot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (s2_free) begin
      v2_r <= shift_en && ctl_in.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_free && shift_en) begin
      ctl2_r <= ctl_in;
    end
  end

  always_comb begin
    for (int x = 0; x < 3; x++) begin
      for (int z = 0; z < 3; z++) begin
        if ((x == 0 && ctl2_r.top_out) || (x == 2 && ctl2_r.bot_out) ||
            (z == 0 && ctl2_r.left_out) || (z == 2 && ctl2_r.right_out)) begin
          view[x][z] = PIXEL_OUTSIDE;
        end else begin
          view[x][z] = win_r[x][z];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (o_en) begin
      out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (o_en && v2_r) begin
      blue_edge_r  <= edge_strength(view[0][0].blue, view[0][1].blue, view[0][2].blue,
                                    view[1][0].blue, view[1][2].blue,
                                    view[2][0].blue, view[2][1].blue, view[2][2].blue);
      green_edge_r <= edge_strength(view[0][0].green, view[0][1].green, view[0][2].green,
                                    view[1][0].green, view[1][2].green,
                                    view[2][0].green, view[2][1].green, view[2][2].green);
      red_edge_r   <= edge_strength(view[0][0].red, view[0][1].red, view[0][2].red,
                                    view[1][0].red, view[1][2].red,
                                    view[2][0].red, view[2][1].red, view[2][2].red);
      last_r       <= ctl2_r.last;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.blue_edge     = blue_edge_r;
  assign out_ch.green_edge    = green_edge_r;
  assign out_ch.red_edge      = red_edge_r;
  assign out_ch.last_of_frame = last_r;

endmodule

@@ test/tb_window_edge_magnitude_rgb.sv @@
// ----------------------------------------------------------------------------
// Window edge magnitude testbench
// Drives raster-order pixel frames through the valid/ready input channel and
// checks every result transaction against a cycle-free predictor of the 3x3
// edge-strength window, covering reset sizes, clamped sizes, flushes inside
// and after frames, truncated frames, random idling and long output stalls.
// ----------------------------------------------------------------------------
module tb_window_edge_magnitude_rgb;
  import wem_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_DIM       = 1024;
  localparam int SETTLE_CYCLES = 8;
  localparam int HOLD_CYCLES   = 400;
  localparam int STALL_LIMIT   = 2000;
  localparam int RANDOM_ITEMS  = 250;

  typedef struct packed {
    logic    flush;
    sample_t red;
    sample_t green;
    sample_t blue;
  } pixel_item_t;

  typedef struct packed {
    sample_t blue;
    sample_t green;
    sample_t red;
    logic    last;
  } edge_result_t;

  typedef pixel_t window_t [3][3];

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  wem_in_if  in_ch ();
  wem_out_if out_ch ();

  window_edge_magnitude_rgb u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  pixel_item_t  pixel_q [$];
  edge_result_t edge_expect_q [$];
  pixel_item_t  in_cur;
  edge_result_t edge_want;

  int unsigned fail_count   = 0;
  int unsigned queued_items = 0;
  int unsigned idle_run     = 0;
  int unsigned gap_pct      = 19;
  logic        out_hold     = 1'b0;
  logic        hold_armed   = 1'b0;

  // Predictor state.
  pixel_t                upper_row_mem [MAX_DIM];
  pixel_t                middle_row_mem [MAX_DIM];
  window_t               win_cells;
  int                    col_pos;
  int                    row_pos;
  logic [CFG_DATA_W-1:0] width_reg;
  logic [CFG_DATA_W-1:0] height_reg;

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  function automatic int frame_dim(input logic [CFG_DATA_W-1:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return int'(v);
  endfunction

  function automatic sample_t sample_gap(input sample_t a, input sample_t b);
    return (a > b) ? sample_t'(a - b) : sample_t'(b - a);
  endfunction

  function automatic sample_t channel_edge(input window_t nb, input int ch);
    sample_t best;
    sample_t d;
    best = sample_gap(nb[0][0][8*ch +: 8], nb[2][2][8*ch +: 8]);
    d = sample_gap(nb[0][1][8*ch +: 8], nb[2][1][8*ch +: 8]);
    if (d > best) best = d;
    d = sample_gap(nb[1][0][8*ch +: 8], nb[1][2][8*ch +: 8]);
    if (d > best) best = d;
    d = sample_gap(nb[0][2][8*ch +: 8], nb[2][0][8*ch +: 8]);
    if (d > best) best = d;
    return best;
  endfunction

  function automatic void reset_tracker();
    width_reg  = 11'd640;
    height_reg = 11'd480;
    for (int i = 0; i < MAX_DIM; i++) begin
      upper_row_mem[i]  = '0;
      middle_row_mem[i] = '0;
    end
    for (int x = 0; x < 3; x++) begin
      for (int z = 0; z < 3; z++) begin
        win_cells[x][z] = PIXEL_OUTSIDE;
      end
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_FRAME_WIDTH) begin
      width_reg = data;
    end else begin
      height_reg = data;
    end
    col_pos = 0;
    row_pos = 0;
  endfunction

  // Advances the window by one accepted transaction and queues a result when it completes a window in the frame.
  function automatic void track_window(input pixel_item_t it);
    int           w;
    int           h;
    int           c;
    int           r;
    int           cr;
    int           cc;
    int           nr;
    int           nc;
    int           x;
    int           z;
    pixel_t       s;
    pixel_t       top;
    pixel_t       mid;
    window_t      nb;
    edge_result_t res;
    w = frame_dim(width_reg);
    h = frame_dim(height_reg);
    c = col_pos;
    r = row_pos;
    if (c >= w) c = 0;
    s = it.flush ? PIXEL_OUTSIDE : pixel_t'({it.red, it.green, it.blue});
    top = upper_row_mem[c];
    mid = middle_row_mem[c];
    upper_row_mem[c]  = mid;
    middle_row_mem[c] = s;
    for (x = 0; x < 3; x++) begin
      win_cells[x][0] = win_cells[x][1];
      win_cells[x][1] = win_cells[x][2];
    end
    win_cells[0][2] = top;
    win_cells[1][2] = mid;
    win_cells[2][2] = s;
    if (c >= 1) begin
      cr = r - 1;
      cc = c - 1;
    end else begin
      cr = r - 2;
      cc = w - 1;
    end
    if (c + 1 >= w) begin
      col_pos = 0;
      if (r < 4095) row_pos = r + 1;
    end else begin
      col_pos = c + 1;
      row_pos = r;
    end
    if (cr < 0 || cr >= h) return;
    for (x = 0; x < 3; x++) begin
      for (z = 0; z < 3; z++) begin
        nr = cr - 1 + x;
        nc = cc - 1 + z;
        nb[x][z] = (nr >= 0 && nr < h && nc >= 0 && nc < w) ? win_cells[x][z] : PIXEL_OUTSIDE;
      end
    end
    res.blue  = channel_edge(nb, 0);
    res.green = channel_edge(nb, 1);
    res.red   = channel_edge(nb, 2);
    res.last  = (cr == h - 1 && cc == w - 1);
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
    end
    edge_expect_q.push_back(res);
  endfunction

  function automatic sample_t pick_sample();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return sample_t'($urandom_range(255));
    endcase
  endfunction

  function automatic void push_item(input logic flush, input sample_t b, input sample_t g,
                                    input sample_t r);
    pixel_item_t it;
    it.flush = flush;
    it.blue  = b;
    it.green = g;
    it.red   = r;
    pixel_q.push_back(it);
    queued_items++;
  endfunction

  function automatic void queue_frame(input bit cut_short);
    int w;
    int h;
    int total;
    int stop;
    w = frame_dim(width_reg);
    h = frame_dim(height_reg);
    total = w * h + w + 1;
    stop = cut_short ? $urandom_range(total - 1) : total;
    for (int i = 0; i < stop; i++) begin
      if (i < w * h) begin
        push_item($urandom_range(99) < 5, pick_sample(), pick_sample(), pick_sample());
      end else begin
        push_item($urandom_range(99) >= 20, pick_sample(), pick_sample(), pick_sample());
      end
    end
  endfunction

  task automatic wait_idle();
    while (pixel_q.size() != 0 || in_ch.valid || edge_expect_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input int unsigned data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data[CFG_DATA_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    apply_register(idx, data[CFG_DATA_W-1:0]);
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid    <= 1'b0;
      in_ch.flush    <= 1'b0;
      in_ch.blue_in  <= '0;
      in_ch.green_in <= '0;
      in_ch.red_in   <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) track_window(in_cur);
      if (!in_ch.valid || in_ch.ready) begin
        if (pixel_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_cur = pixel_q.pop_front();
          in_ch.valid    <= 1'b1;
          in_ch.flush    <= in_cur.flush;
          in_ch.blue_in  <= in_cur.blue;
          in_ch.green_in <= in_cur.green;
          in_ch.red_in   <= in_cur.red;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= !out_hold && ($urandom_range(99) >= gap_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (edge_expect_q.size() == 0) begin
          $error("result transaction with no expectation pending");
          fail_count++;
        end else begin
          edge_want = edge_expect_q.pop_front();
          check_field("blue_edge", edge_want.blue, out_ch.blue_edge);
          check_field("green_edge", edge_want.green, out_ch.green_edge);
          check_field("red_edge", edge_want.red, out_ch.red_edge);
          check_field("last_of_frame", edge_want.last, out_ch.last_of_frame);
        end
      end
    end
  end

  initial begin
    wait (hold_armed);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_run <= 0;
      end else begin
        idle_run <= idle_run + 1;
      end
      if (idle_run == STALL_LIMIT) begin
        $display("FAIL window_edge_magnitude_rgb");
        $finish;
      end
    end
  end

  initial begin
    int unsigned random_start;
    int unsigned frames;
    reset_tracker();
    rst_n     <= 1'b0;
    cfg_we    <= 1'b0;
    cfg_index <= '0;
    cfg_wdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset sizes: one row and a bit of the next is enough to see results.
    // This stretch also runs without any idling.
    gap_pct = 0;
    for (int i = 0; i < 660; i++) begin
      push_item(1'b0, pick_sample(), pick_sample(), pick_sample());
    end
    wait_idle();
    gap_pct = 19;

    write_register(REG_FRAME_WIDTH, 4);
    write_register(REG_FRAME_HEIGHT, 3);
    push_item(1'b0, 8'd0, 8'd0, 8'd0);
    push_item(1'b0, 8'd255, 8'd255, 8'd255);
    push_item(1'b0, 8'd0, 8'd0, 8'd0);
    push_item(1'b0, 8'd255, 8'd255, 8'd255);
    push_item(1'b0, 8'd255, 8'd0, 8'd128);
    push_item(1'b1, 8'd0, 8'd0, 8'd0);
    push_item(1'b0, 8'd0, 8'd255, 8'd1);
    push_item(1'b0, 8'd128, 8'd0, 8'd255);
    push_item(1'b0, 8'd255, 8'd255, 8'd255);
    push_item(1'b0, 8'd0, 8'd0, 8'd0);
    push_item(1'b0, 8'd255, 8'd0, 8'd255);
    push_item(1'b0, 8'd0, 8'd255, 8'd0);
    push_item(1'b1, 8'd255, 8'd255, 8'd255);
    push_item(1'b0, 8'd17, 8'd34, 8'd51);
    push_item(1'b1, 8'd0, 8'd0, 8'd0);
    push_item(1'b1, 8'd0, 8'd0, 8'd0);
    push_item(1'b1, 8'd0, 8'd0, 8'd0);
    wait_idle();

    write_register(REG_FRAME_WIDTH, 1);
    write_register(REG_FRAME_HEIGHT, 1);
    push_item(1'b0, 8'd0, 8'd255, 8'd0);
    push_item(1'b1, 8'd255, 8'd255, 8'd255);
    push_item(1'b0, 8'd255, 8'd0, 8'd255);
    wait_idle();

    // Both registers at zero act as a one-pixel frame.
    write_register(REG_FRAME_WIDTH, 0);
    write_register(REG_FRAME_HEIGHT, 0);
    queue_frame(1'b0);
    wait_idle();

    // Long output stall while input keeps coming.
    write_register(REG_FRAME_WIDTH, 5);
    write_register(REG_FRAME_HEIGHT, 6);
    hold_armed = 1'b1;
    for (int f = 0; f < 6; f++) queue_frame(1'b0);
    wait_idle();

    random_start = queued_items;
    while (queued_items - random_start < RANDOM_ITEMS) begin
      if ($urandom_range(3) != 0) write_register(REG_FRAME_WIDTH, $urandom_range(1, 12));
      if ($urandom_range(3) != 0) write_register(REG_FRAME_HEIGHT, $urandom_range(1, 8));
      frames = $urandom_range(1, 4);
      for (int f = 0; f < frames; f++) begin
        queue_frame(f == frames - 1 && $urandom_range(9) == 0);
      end
      wait_idle();
    end

    repeat (20) @(posedge clk);
    if (fail_count == 0 && edge_expect_q.size() == 0) begin
      $display("PASS window_edge_magnitude_rgb");
    end else begin
      $display("FAIL window_edge_magnitude_rgb");
    end
    $finish;
  end

endmodule
